>>> hdl/rtvl_pkg.sv
// Shared types, widths and codes for the rate-to-voltage linearizer.
`timescale 1ns / 1ps
`default_nettype none

package rtvl_pkg;

  localparam int RateW    = 16;             // Q2.14 rate command
  localparam int CoefW    = 32;             // Q8.24 coefficient or voltage
  localparam int AccW     = 36;             // Horner accumulator, -2^35 <= acc < 2^35
  localparam int ProdW    = AccW + RateW;   // full accumulator-by-rate product
  localparam int FracRate = 14;             // fraction bits of the rate
  localparam int DzW      = 15;             // dead-zone threshold width
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int NumSteps = 4;              // Horner steps after the leading coefficient

  // 1400/1300 in Q2.14, rounded
  localparam logic signed [RateW-1:0] MaxRate = 16'sd17644;
  localparam logic signed [RateW-1:0] MinRate = -16'sd17644;

  localparam logic signed [CoefW-1:0] VoltMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoefW-1:0] VoltMin = 32'sh8000_0000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCoefFourth = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefThird  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefSecond = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefLinear = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefOffset = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDeadZone   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegIdleVolt   = 3'd6;

  typedef struct packed {
    logic [2*CoefW-1:0] fourth;
    logic [2*CoefW-1:0] third;
    logic [2*CoefW-1:0] second;
    logic [2*CoefW-1:0] linear;
    logic [2*CoefW-1:0] offset;
    logic [DzW-1:0]     dead_zone;
    logic [CoefW-1:0]   idle;
  } cfg_t;

  // per-item flags that ride along with the data
  typedef struct packed {
    logic cw;
    logic clamped;
    logic dead;
  } tag_t;

  // clockwise coefficient in the upper half, counter-clockwise in the lower
  function automatic logic [AccW-1:0] pick_coef(input logic [2*CoefW-1:0] pair,
                                                input logic cw);
    logic [CoefW-1:0] c;
    c = cw ? pair[2*CoefW-1:CoefW] : pair[CoefW-1:0];
    return {{(AccW-CoefW){c[CoefW-1]}}, c};
  endfunction

endpackage

`default_nettype wire

>>> hdl/rtvl_cfg_regs.sv
// Configuration register file for the coefficients, dead zone and idle voltage.
`timescale 1ns / 1ps
`default_nettype none

module rtvl_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rtvl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rtvl_pkg::CfgDataW-1:0] cfg_data_i,
  output rtvl_pkg::cfg_t                     cfg_o
);
  import rtvl_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCoefFourth: cfg_d.fourth    = cfg_data_i;
        RegCoefThird:  cfg_d.third     = cfg_data_i;
        RegCoefSecond: cfg_d.second    = cfg_data_i;
        RegCoefLinear: cfg_d.linear    = cfg_data_i;
        RegCoefOffset: cfg_d.offset    = cfg_data_i;
        RegDeadZone:   cfg_d.dead_zone = cfg_data_i[DzW-1:0];
        RegIdleVolt:   cfg_d.idle      = cfg_data_i[CoefW-1:0];
        default:       cfg_d = cfg_q;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hdl/rtvl_front.sv
// Front stage: clamp the rate, pick the polynomial side and load the leading coefficient.
`timescale 1ns / 1ps
`default_nettype none

module rtvl_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic signed [rtvl_pkg::RateW-1:0] rate_i,
  input  wire logic [rtvl_pkg::DzW-1:0]          dead_zone_i,
  input  wire logic [2*rtvl_pkg::CoefW-1:0]      coef_pair_i,
  output logic                                   valid_o,
  output logic signed [rtvl_pkg::RateW-1:0]      w_o,
  output logic signed [rtvl_pkg::AccW-1:0]       acc_o,
  output rtvl_pkg::tag_t                         tag_o
);
  import rtvl_pkg::*;

  logic                     valid_q;
  logic signed [RateW-1:0]  w_q, w_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  tag_t                     tag_q, tag_d;
  logic signed [RateW:0]    w_ext, dz_pos, dz_neg;
  logic                     ccw;

  always_comb begin
    w_d           = rate_i;
    tag_d.clamped = 1'b0;
    if (rate_i > MaxRate) begin
      w_d           = MaxRate;
      tag_d.clamped = 1'b1;
    end else if (rate_i < MinRate) begin
      w_d           = MinRate;
      tag_d.clamped = 1'b1;
    end
    w_ext     = {w_d[RateW-1], w_d};
    dz_pos    = $signed({{(RateW+1-DzW){1'b0}}, dead_zone_i});
    dz_neg    = -dz_pos;
    tag_d.cw  = (w_ext >= dz_pos);
    ccw       = (w_ext <= dz_neg);
    tag_d.dead = !(tag_d.cw || ccw);
    acc_d     = $signed(pick_coef(coef_pair_i, tag_d.cw));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q   <= w_d;
      acc_q <= acc_d;
      tag_q <= tag_d;
    end
  end

  assign valid_o = valid_q;
  assign w_o     = w_q;
  assign acc_o   = acc_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

>>> hdl/rtvl_horner_step.sv
// One Horner step in two stages: multiply by the rate, then round and add the next coefficient.
`timescale 1ns / 1ps
`default_nettype none

module rtvl_horner_step (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic signed [rtvl_pkg::RateW-1:0] w_i,
  input  wire logic signed [rtvl_pkg::AccW-1:0]  acc_i,
  input  wire rtvl_pkg::tag_t                    tag_i,
  input  wire logic [2*rtvl_pkg::CoefW-1:0]      coef_pair_i,
  output logic                                   valid_o,
  output logic signed [rtvl_pkg::RateW-1:0]      w_o,
  output logic signed [rtvl_pkg::AccW-1:0]       acc_o,
  output rtvl_pkg::tag_t                         tag_o
);
  import rtvl_pkg::*;

  localparam logic signed [ProdW-1:0] Half = ProdW'(1) <<< (FracRate - 1);

  // multiply stage
  logic                     mul_valid_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [RateW-1:0]  mul_w_q;
  tag_t                     mul_tag_q;

  // round-and-add stage
  logic                     add_valid_q;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [RateW-1:0]  add_w_q;
  tag_t                     add_tag_q;

  logic signed [ProdW-1:0]  rounded;
  logic signed [ProdW-1:0]  shifted;

  always_comb begin
    // half-up rounding: floor((p + 2^13) / 2^14)
    rounded = prod_q + Half;
    shifted = rounded >>> FracRate;
    acc_d   = $signed(shifted[AccW-1:0]) + $signed(pick_coef(coef_pair_i, mul_tag_q.cw));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      add_valid_q <= 1'b0;
    end else if (en_i) begin
      mul_valid_q <= valid_i;
      add_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= ProdW'(acc_i) * ProdW'(w_i);
      mul_w_q   <= w_i;
      mul_tag_q <= tag_i;
      acc_q     <= acc_d;
      add_w_q   <= mul_w_q;
      add_tag_q <= mul_tag_q;
    end
  end

  assign valid_o = add_valid_q;
  assign w_o     = add_w_q;
  assign acc_o   = acc_q;
  assign tag_o   = add_tag_q;

endmodule

`default_nettype wire

>>> hdl/rate_to_voltage_linearizer.sv
// Top level of the rate-to-voltage linearizer: front stage, Horner pipeline and output register.
// The block takes one rate command per cycle while the output side keeps up and returns one
// drive voltage for each, in order: the front stage clamps and classifies, each of the four
// Horner steps multiplies (36x16) and then rounds and adds, and the result is saturated into
// the output register. The whole pipeline advances together; it holds while a result sits
// in the output register untaken, and input is accepted again in the same cycle that result
// is taken. Configuration writes are accepted in every cycle; the user must make them only
// while the block has drained, as the block does not enforce this and each stage reads them live.
`timescale 1ns / 1ps
`default_nettype none

module rate_to_voltage_linearizer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [rtvl_pkg::RateW-1:0]   rate_command_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [rtvl_pkg::CoefW-1:0]        drive_voltage_o,
  output logic                                     rate_clamped_o,
  output logic                                     in_dead_zone_o,
  output logic                                     voltage_saturated_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [rtvl_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [rtvl_pkg::CfgDataW-1:0]       cfg_data_i
);
  import rtvl_pkg::*;

  cfg_t                     cfg;
  logic                     adv;
  logic [2*CoefW-1:0]       step_pair [NumSteps];

  logic                     st_valid [NumSteps+1];
  logic signed [RateW-1:0]  st_w     [NumSteps+1];
  logic signed [AccW-1:0]   st_acc   [NumSteps+1];
  tag_t                     st_tag   [NumSteps+1];

  logic                     out_valid_q;
  logic signed [CoefW-1:0]  volt_q, volt_d;
  logic                     clamped_q, dead_q, sat_q, sat_d;
  logic                     overflow;
  logic signed [AccW-1:0]   acc_last;

  rtvl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // advance every stage whenever the output register is free or being emptied
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  assign step_pair[0] = cfg.third;
  assign step_pair[1] = cfg.second;
  assign step_pair[2] = cfg.linear;
  assign step_pair[3] = cfg.offset;

  rtvl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (in_valid_i),
    .rate_i      (rate_command_i),
    .dead_zone_i (cfg.dead_zone),
    .coef_pair_i (cfg.fourth),
    .valid_o     (st_valid[0]),
    .w_o         (st_w[0]),
    .acc_o       (st_acc[0]),
    .tag_o       (st_tag[0])
  );

  for (genvar s = 0; s < NumSteps; s++) begin : g_step
    rtvl_horner_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (adv),
      .valid_i     (st_valid[s]),
      .w_i         (st_w[s]),
      .acc_i       (st_acc[s]),
      .tag_i       (st_tag[s]),
      .coef_pair_i (step_pair[s]),
      .valid_o     (st_valid[s+1]),
      .w_o         (st_w[s+1]),
      .acc_o       (st_acc[s+1]),
      .tag_o       (st_tag[s+1])
    );
  end

  always_comb begin
    acc_last = st_acc[NumSteps];
    // overflow when the bits above the sign of a 32-bit result disagree
    overflow = !((&acc_last[AccW-1:CoefW-1]) || !(|acc_last[AccW-1:CoefW-1]));
    sat_d    = 1'b0;
    if (st_tag[NumSteps].dead) begin
      volt_d = $signed(cfg.idle);
    end else if (overflow) begin
      volt_d = acc_last[AccW-1] ? VoltMin : VoltMax;
      sat_d  = 1'b1;
    end else begin
      volt_d = $signed(acc_last[CoefW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= st_valid[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      volt_q    <= volt_d;
      clamped_q <= st_tag[NumSteps].clamped;
      dead_q    <= st_tag[NumSteps].dead;
      sat_q     <= sat_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign drive_voltage_o     = volt_q;
  assign rate_clamped_o      = clamped_q;
  assign in_dead_zone_o      = dead_q;
  assign voltage_saturated_o = sat_q;

  a_dead_not_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(in_dead_zone_o && voltage_saturated_o))
    else $error("dead-zone result flagged as saturated");

  a_sat_extreme : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && voltage_saturated_o |->
      (drive_voltage_o == VoltMax) || (drive_voltage_o == VoltMin))
    else $error("saturated result is not a range limit");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while the pipeline is stalled");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_voltage_o))
    else $error("pending result changed during a stall");

endmodule

`default_nettype wire

>>> verif/rate_to_voltage_linearizer_tb.sv
// Self-checking testbench for the rate-to-voltage linearizer: random handshakes, predicted voltages.
`timescale 1ns / 1ps

module rate_to_voltage_linearizer_tb;
  import rtvl_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;  // no register behind this index
  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 14;

  typedef struct packed {
    logic signed [CoefW-1:0] volt;
    logic                    clamped;
    logic                    dead;
    logic                    sat;
  } drive_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [RateW-1:0]    rate_command_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [CoefW-1:0]    drive_voltage_o;
  logic                       rate_clamped_o;
  logic                       in_dead_zone_o;
  logic                       voltage_saturated_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i = '0;
  logic [CfgDataW-1:0]        cfg_data_i = '0;

  // shadow of the block's registers, updated on each accepted write
  logic [2*CoefW-1:0]         coef_model [5];
  logic [DzW-1:0]             dz_model = '0;
  logic [CoefW-1:0]           idle_model = '0;

  logic [RateW-1:0]           rate_queue [$];
  drive_result_t              expected_drive [$];
  logic [CfgDataW-1:0]        next_setting [8];

  bit                         in_accepted = 1'b0;
  bit                         cfg_accepted = 1'b0;
  int                         send_idle_pct = 28;
  int                         recv_idle_pct = 28;
  int                         hold_cycles = 0;
  int                         mismatch_count = 0;
  int                         cycle_count = 0;

  rate_to_voltage_linearizer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .rate_command_i     (rate_command_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .drive_voltage_o    (drive_voltage_o),
    .rate_clamped_o     (rate_clamped_o),
    .in_dead_zone_o     (in_dead_zone_o),
    .voltage_saturated_o(voltage_saturated_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (coef_model[i]) coef_model[i] = '0;
  end

  function automatic longint branch_coef(input logic [2*CoefW-1:0] pair, input bit cw);
    logic signed [CoefW-1:0] c;
    c = cw ? pair[2*CoefW-1:CoefW] : pair[CoefW-1:0];
    return c;
  endfunction

  // clamp, classify, then Horner with round-half-up after each multiply
  function automatic drive_result_t linearize_rate(input logic signed [RateW-1:0] rate);
    drive_result_t r;
    longint        w;
    longint        dz;
    longint        acc;
    bit            cw;
    r  = '0;
    w  = rate;
    dz = dz_model;
    if (w > MaxRate) begin
      w = MaxRate;
      r.clamped = 1'b1;
    end else if (w < MinRate) begin
      w = MinRate;
      r.clamped = 1'b1;
    end
    if (w >= dz || w <= -dz) begin
      cw  = (w >= dz);
      acc = branch_coef(coef_model[RegCoefFourth], cw);
      for (int k = RegCoefThird; k <= RegCoefOffset; k++) begin
        acc = ((acc * w + (longint'(1) <<< (FracRate - 1))) >>> FracRate)
              + branch_coef(coef_model[k], cw);
      end
      if (acc > longint'(VoltMax)) begin
        r.volt = VoltMax;
        r.sat  = 1'b1;
      end else if (acc < longint'(VoltMin)) begin
        r.volt = VoltMin;
        r.sat  = 1'b1;
      end else begin
        r.volt = acc[CoefW-1:0];
      end
    end else begin
      r.volt = idle_model;
      r.dead = 1'b1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // driver: advance to the next command once the current one is taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_accepted) begin
      if (rate_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i     <= 1'b1;
        rate_command_i <= rate_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: track register writes, predict on input, check on output
  always @(posedge clk_i) begin
    drive_result_t got;
    drive_result_t want;
    in_accepted  = rst_ni && in_valid_i && in_ready_o;
    cfg_accepted = rst_ni && cfg_valid_i && cfg_ready_o;
    if (cfg_accepted) begin
      case (cfg_index_i)
        RegCoefFourth, RegCoefThird, RegCoefSecond, RegCoefLinear, RegCoefOffset:
          coef_model[cfg_index_i] = cfg_data_i;
        RegDeadZone: dz_model   = cfg_data_i[DzW-1:0];
        RegIdleVolt: idle_model = cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
    if (in_accepted) expected_drive.push_back(linearize_rate(rate_command_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {drive_voltage_o, rate_clamped_o, in_dead_zone_o, voltage_saturated_o};
      if (expected_drive.size() == 0) begin
        flag_mismatch("unexpected transaction, drive_voltage", got.volt, 0);
      end else begin
        want = expected_drive.pop_front();
        if (got.volt !== want.volt) flag_mismatch("drive_voltage", got.volt, want.volt);
        if (got.clamped !== want.clamped)
          flag_mismatch("rate_clamped", got.clamped, want.clamped);
        if (got.dead !== want.dead) flag_mismatch("in_dead_zone", got.dead, want.dead);
        if (got.sat !== want.sat) flag_mismatch("voltage_saturated", got.sat, want.sat);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("rate_to_voltage_linearizer_tb failed");
      $finish;
    end
  end

  function automatic logic [CoefW-1:0] modest_coef();
    logic signed [CoefW-1:0] c;
    c = $urandom;
    return c >>> $urandom_range(20, 4);
  endfunction

  task automatic draw_setting(input int dz);
    for (int k = RegCoefFourth; k <= RegCoefOffset; k++) begin
      if ($urandom_range(3) == 0) next_setting[k] = {$urandom, $urandom};
      else next_setting[k] = {modest_coef(), modest_coef()};
    end
    next_setting[RegDeadZone]          = {$urandom, $urandom};
    next_setting[RegDeadZone][DzW-1:0] = DzW'(dz);
    next_setting[RegIdleVolt]          = {$urandom, $urandom};
    next_setting[RegUnused]            = {$urandom, $urandom};
  endtask

  // write every index in turn, the unused one included
  task automatic load_setting();
    @(negedge clk_i);
    for (int i = 0; i <= RegUnused; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i  <= next_setting[i];
      do @(negedge clk_i); while (!cfg_accepted);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (rate_queue.size() != 0 || in_valid_i || expected_drive.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [RateW-1:0] draw_rate(input int dz);
    int t;
    case ($urandom_range(4))
      0, 1: return RateW'($urandom);
      2: return RateW'(int'($urandom_range(2 * MaxRate)) - MaxRate);
      3: t = dz + int'($urandom_range(4)) - 2;
      default: t = MaxRate + int'($urandom_range(2)) - 1;
    endcase
    return $urandom_range(1) ? RateW'(t) : RateW'(-t);
  endfunction

  initial begin
    int burst [$];
    int dz;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: zero threshold, all coefficients zero
    burst = '{0, 1, -1, 32767, -32768, 17644, 17645, -17644, -17645};
    foreach (burst[i]) rate_queue.push_back(RateW'(burst[i]));
    wait_idle();

    // hand-picked curves, threshold edges on both sides, over-wide register data
    next_setting[RegCoefFourth] = {32'sh0010_0000, 32'shFFF0_0000};
    next_setting[RegCoefThird]  = {32'shFFE0_0000, 32'sh0030_0000};
    next_setting[RegCoefSecond] = {32'sh0080_0000, 32'shFF40_0000};
    next_setting[RegCoefLinear] = {32'sh0100_0000, 32'sh0180_0000};
    next_setting[RegCoefOffset] = {32'sh0020_0000, 32'shFFE0_0000};
    next_setting[RegDeadZone]   = 64'hA5A5_0000_0000_83E8;
    next_setting[RegIdleVolt]   = 64'hDEAD_BEEF_0123_4567;
    next_setting[RegUnused]     = 64'hFFFF_FFFF_FFFF_FFFF;
    load_setting();
    burst = '{1000, 999, -1000, -999, 0, 17644, -17644, 32767, -32768, 17000};
    foreach (burst[i]) rate_queue.push_back(RateW'(burst[i]));
    wait_idle();

    // full-scale coefficients: drive both saturation rails
    next_setting[RegCoefFourth] = {32'sh7FFF_FFFF, 32'sh8000_0000};
    next_setting[RegCoefThird]  = {32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    next_setting[RegCoefSecond] = {32'sh7FFF_FFFF, 32'sh8000_0000};
    next_setting[RegCoefLinear] = {32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    next_setting[RegCoefOffset] = {32'sh7FFF_FFFF, 32'sh8000_0000};
    next_setting[RegDeadZone]   = '0;
    load_setting();
    burst = '{17644, 32767, -17644, -32768};
    foreach (burst[i]) rate_queue.push_back(RateW'(burst[i]));
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0: dz = 0;
        1: dz = MaxRate;
        2: dz = MaxRate + 1;
        3: dz = 2 ** DzW - 1;
        default: dz = $urandom_range(1) ? $urandom_range(MaxRate) : $urandom_range(64);
      endcase
      draw_setting(dz);
      load_setting();
      // one phase runs with no idling on either side
      send_idle_pct = (p == 4) ? 0 : 28;
      recv_idle_pct = (p == 4) ? 0 : 28;
      repeat (100) rate_queue.push_back(draw_rate(dz));
      wait_idle();
    end

    // hold the output side off while commands keep coming, so the pipeline backs up
    dz = $urandom_range(MaxRate);
    draw_setting(dz);
    load_setting();
    send_idle_pct = 0;
    recv_idle_pct = 28;
    hold_cycles   = 300;
    repeat (150) rate_queue.push_back(draw_rate(dz));
    wait_idle();

    if (mismatch_count == 0) begin
      $display("rate_to_voltage_linearizer_tb passed");
    end else begin
      $display("rate_to_voltage_linearizer_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rtvl_pkg.sv
hdl/rtvl_cfg_regs.sv
hdl/rtvl_front.sv
hdl/rtvl_horner_step.sv
hdl/rate_to_voltage_linearizer.sv
verif/rate_to_voltage_linearizer_tb.sv
